/* sv/thpc_pkg.sv */
// ----------------------------------------------------------------------------
// thpc_pkg: shared types for the TCP header parser and checksum block
// Payload structs for the byte stream and the per-segment summary.
// ----------------------------------------------------------------------------
package thpc_pkg;

  localparam int unsigned CNT_W = 16;
  localparam int unsigned PSUM_W = 19;
  localparam int unsigned SUM_W = 21;

  typedef struct packed {
    logic [7:0]  seg_byte;
    logic        first_byte;
    logic        last_byte;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [7:0]  proto_num;
  } in_item_t;

  typedef struct packed {
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [31:0] seq_num;
    logic [31:0] ack_num;
    logic [15:0] window_size;
    logic [7:0]  flag_bits;
    logic [15:0] checksum_value;
    logic        checksum_good;
    logic [15:0] seg_length;
  } out_item_t;

endpackage

/* sv/thpc_in_if.sv */
// ----------------------------------------------------------------------------
// thpc_in_if: segment byte channel
// Valid/ready channel carrying one segment byte with its pseudo-header fields.
// ----------------------------------------------------------------------------
interface thpc_in_if;
  logic                valid;
  logic                ready;
  thpc_pkg::in_item_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* sv/thpc_out_if.sv */
// ----------------------------------------------------------------------------
// thpc_out_if: segment summary channel
// Valid/ready channel carrying the parsed header fields and checksum result.
// ----------------------------------------------------------------------------
interface thpc_out_if;
  logic                valid;
  logic                ready;
  thpc_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* sv/tcp_header_parse_checksum.sv */
// Path: a byte transaction reaches out_ch through the input register, then the
//   result register.
// Throughput: one byte per cycle; the only stall is a last byte meeting a
//   summary that the sink has not taken yet.
// Reset: synchronous active-low rst_n clears valids, checksum and header state.
// ----------------------------------------------------------------------------
// tcp_header_parse_checksum: TCP header parser with Internet checksum
// Captures ports, sequence, ack, window and flags; accumulates the
// ones'-complement sum over pseudo-header and segment; emits at the last byte.
// ----------------------------------------------------------------------------
module tcp_header_parse_checksum #(
  parameter int unsigned MAX_SEGMENT_BYTES = 65535
) (
  input  logic       clk,
  input  logic       rst_n,
  thpc_in_if.sink    in_ch,
  thpc_out_if.source out_ch
);
  import thpc_pkg::*;

  localparam logic [CNT_W-1:0] MaxCnt = CNT_W'(MAX_SEGMENT_BYTES);

  // input register
  logic              in_vld_r;
  in_item_t          in_r;
  logic [PSUM_W-1:0] psum_r;
  logic              advance;

  // segment state
  logic [15:0]      sum_r, sum_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [7:0]       held_r, held_nxt;
  logic [15:0]      sport_r, sport_nxt;
  logic [15:0]      dport_r, dport_nxt;
  logic [31:0]      seq_r, seq_nxt;
  logic [31:0]      ack_r, ack_nxt;
  logic [15:0]      win_r, win_nxt;
  logic [7:0]       flags_r, flags_nxt;

  // result register
  logic      out_vld_r;
  out_item_t out_r, out_nxt;

  logic [CNT_W-1:0] pos;
  logic             take;
  logic [15:0]      word_add, pad_add, len_add, base_sum;
  logic [PSUM_W-1:0] ps_add;
  logic [SUM_W-1:0] total;
  logic [16:0]      fold1;
  logic [15:0]      fold2;

  assign advance     = in_vld_r && (!in_r.last_byte || !out_vld_r || out_ch.ready);
  assign in_ch.ready = !in_vld_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_vld_r <= in_ch.valid;
    end
    if (in_ch.ready && in_ch.valid) begin
      in_r   <= in_ch.data;
      psum_r <= PSUM_W'(in_ch.data.src_addr[31:16]) + PSUM_W'(in_ch.data.src_addr[15:0])
              + PSUM_W'(in_ch.data.dst_addr[31:16]) + PSUM_W'(in_ch.data.dst_addr[15:0])
              + PSUM_W'(in_ch.data.proto_num);
    end
  end

  always_comb begin
    base_sum  = in_r.first_byte ? 16'd0 : sum_r;
    ps_add    = in_r.first_byte ? psum_r : '0;
    pos       = in_r.first_byte ? '0 : cnt_r;
    held_nxt  = in_r.first_byte ? 8'd0 : held_r;
    sport_nxt = in_r.first_byte ? 16'd0 : sport_r;
    dport_nxt = in_r.first_byte ? 16'd0 : dport_r;
    seq_nxt   = in_r.first_byte ? 32'd0 : seq_r;
    ack_nxt   = in_r.first_byte ? 32'd0 : ack_r;
    win_nxt   = in_r.first_byte ? 16'd0 : win_r;
    flags_nxt = in_r.first_byte ? 8'd0 : flags_r;
    take      = pos < MaxCnt;
    cnt_nxt   = pos;
    word_add  = 16'd0;
    if (take) begin
      if (pos < CNT_W'(2)) begin
        sport_nxt = {sport_nxt[7:0], in_r.seg_byte};
      end else if (pos < CNT_W'(4)) begin
        dport_nxt = {dport_nxt[7:0], in_r.seg_byte};
      end else if (pos < CNT_W'(8)) begin
        seq_nxt = {seq_nxt[23:0], in_r.seg_byte};
      end else if (pos < CNT_W'(12)) begin
        ack_nxt = {ack_nxt[23:0], in_r.seg_byte};
      end else if (pos == CNT_W'(13)) begin
        flags_nxt = in_r.seg_byte;
      end else if (pos == CNT_W'(14) || pos == CNT_W'(15)) begin
        win_nxt = {win_nxt[7:0], in_r.seg_byte};
      end
      if (!pos[0]) begin
        held_nxt = in_r.seg_byte;
      end else begin
        word_add = {held_nxt, in_r.seg_byte};
      end
      cnt_nxt = pos + CNT_W'(1);
    end
    pad_add = (in_r.last_byte && cnt_nxt[0]) ? {held_nxt, 8'd0} : 16'd0;
    len_add = in_r.last_byte ? cnt_nxt : 16'd0;
    total   = SUM_W'(base_sum) + SUM_W'(ps_add) + SUM_W'(word_add)
            + SUM_W'(pad_add) + SUM_W'(len_add);
    fold1   = 17'(total[15:0]) + 17'(total[SUM_W-1:16]);
    fold2   = fold1[15:0] + 16'(fold1[16]);
    sum_nxt = fold2;

    out_nxt.src_port       = sport_nxt;
    out_nxt.dst_port       = dport_nxt;
    out_nxt.seq_num        = seq_nxt;
    out_nxt.ack_num        = ack_nxt;
    out_nxt.window_size    = win_nxt;
    out_nxt.flag_bits      = flags_nxt;
    out_nxt.checksum_value = ~fold2;
    out_nxt.checksum_good  = (fold2 == 16'hFFFF);
    out_nxt.seg_length     = cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r   <= '0;
      cnt_r   <= '0;
      held_r  <= '0;
      sport_r <= '0;
      dport_r <= '0;
      seq_r   <= '0;
      ack_r   <= '0;
      win_r   <= '0;
      flags_r <= '0;
    end else if (advance) begin
      if (in_r.last_byte) begin
        sum_r   <= '0;
        cnt_r   <= '0;
        held_r  <= '0;
        sport_r <= '0;
        dport_r <= '0;
        seq_r   <= '0;
        ack_r   <= '0;
        win_r   <= '0;
        flags_r <= '0;
      end else begin
        sum_r   <= sum_nxt;
        cnt_r   <= cnt_nxt;
        held_r  <= held_nxt;
        sport_r <= sport_nxt;
        dport_r <= dport_nxt;
        seq_r   <= seq_nxt;
        ack_r   <= ack_nxt;
        win_r   <= win_nxt;
        flags_r <= flags_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance && in_r.last_byte) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
    if (advance && in_r.last_byte) begin
      out_r <= out_nxt;
    end
  end

  assign out_ch.valid = out_vld_r;
  assign out_ch.data  = out_r;

endmodule

/* verif/thpc_segment_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thpc_segment_checker: segment summary predictor and comparator
// Watches the byte and summary channels. Tracks header capture, byte count
// and the ones'-complement sum per segment, queues the expected summary at
// each last byte and compares every summary transaction field by field.
// ----------------------------------------------------------------------------
module thpc_segment_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  thpc_pkg::in_item_t  in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  thpc_pkg::out_item_t out_data,
  output int                  fail_count,
  output int                  pending_count
);
  import thpc_pkg::*;

  localparam logic [15:0] SEG_LIMIT = 16'hFFFF;

  logic [15:0] csum_acc;
  logic [15:0] byte_total;
  logic [7:0]  even_byte;
  logic [15:0] sport;
  logic [15:0] dport;
  logic [31:0] seq_val;
  logic [31:0] ack_val;
  logic [15:0] win_val;
  logic [7:0]  flag_val;

  out_item_t summary_q[$];

  function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] t;
    t = {1'b0, a} + {1'b0, b};
    return t[15:0] + {15'd0, t[16]};
  endfunction

  task automatic clear_segment();
    csum_acc   = '0;
    byte_total = '0;
    even_byte  = '0;
    sport      = '0;
    dport      = '0;
    seq_val    = '0;
    ack_val    = '0;
    win_val    = '0;
    flag_val   = '0;
  endtask

  task automatic take_byte(input in_item_t item);
    out_item_t summary;
    logic [15:0] chk;
    if (item.first_byte) begin
      clear_segment();
      csum_acc = ones_add(csum_acc, item.src_addr[31:16]);
      csum_acc = ones_add(csum_acc, item.src_addr[15:0]);
      csum_acc = ones_add(csum_acc, item.dst_addr[31:16]);
      csum_acc = ones_add(csum_acc, item.dst_addr[15:0]);
      csum_acc = ones_add(csum_acc, {8'h00, item.proto_num});
    end
    if (byte_total < SEG_LIMIT) begin
      if (byte_total < 16'd2) begin
        sport = {sport[7:0], item.seg_byte};
      end else if (byte_total < 16'd4) begin
        dport = {dport[7:0], item.seg_byte};
      end else if (byte_total < 16'd8) begin
        seq_val = {seq_val[23:0], item.seg_byte};
      end else if (byte_total < 16'd12) begin
        ack_val = {ack_val[23:0], item.seg_byte};
      end else if (byte_total == 16'd13) begin
        flag_val = item.seg_byte;
      end else if (byte_total == 16'd14 || byte_total == 16'd15) begin
        win_val = {win_val[7:0], item.seg_byte};
      end
      if (!byte_total[0]) begin
        even_byte = item.seg_byte;
      end else begin
        csum_acc = ones_add(csum_acc, {even_byte, item.seg_byte});
      end
      byte_total = byte_total + 16'd1;
    end
    if (item.last_byte) begin
      if (byte_total[0]) begin
        csum_acc = ones_add(csum_acc, {even_byte, 8'h00});
      end
      csum_acc = ones_add(csum_acc, byte_total);
      chk = ~csum_acc;
      summary.src_port       = sport;
      summary.dst_port       = dport;
      summary.seq_num        = seq_val;
      summary.ack_num        = ack_val;
      summary.window_size    = win_val;
      summary.flag_bits      = flag_val;
      summary.checksum_value = chk;
      summary.checksum_good  = (chk == 16'h0000);
      summary.seg_length     = byte_total;
      summary_q.push_back(summary);
      clear_segment();
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
      fail_count++;
    end
  endtask

  task automatic check_summary(input out_item_t got);
    out_item_t want;
    if (summary_q.size() == 0) begin
      $error("summary transaction with no segment outstanding");
      fail_count++;
    end else begin
      want = summary_q.pop_front();
      check_field("src_port", 32'(want.src_port), 32'(got.src_port));
      check_field("dst_port", 32'(want.dst_port), 32'(got.dst_port));
      check_field("seq_num", want.seq_num, got.seq_num);
      check_field("ack_num", want.ack_num, got.ack_num);
      check_field("window_size", 32'(want.window_size), 32'(got.window_size));
      check_field("flag_bits", 32'(want.flag_bits), 32'(got.flag_bits));
      check_field("checksum_value", 32'(want.checksum_value), 32'(got.checksum_value));
      check_field("checksum_good", 32'(want.checksum_good), 32'(got.checksum_good));
      check_field("seg_length", 32'(want.seg_length), 32'(got.seg_length));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_segment();
      summary_q.delete();
      fail_count = 0;
    end else begin
      if (out_valid && out_ready) begin
        check_summary(out_data);
      end
      if (in_valid && in_ready) begin
        take_byte(in_data);
      end
    end
    pending_count = summary_q.size();
  end

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: TCP header parser and checksum block
// Drives directed segments, one overlong segment and random segments with
// valid and corrupted checksums, missing marks and restarts, under random
// source gaps and sink stalls. The checker predicts and compares summaries.
// ----------------------------------------------------------------------------
module testbench;
  import thpc_pkg::*;

  logic clk;
  logic rst_n;
  bit   idle_on;
  bit   stall_on;
  int   fail_count;
  int   pending_count;
  int   rand_bytes;
  int   rand_closed;

  thpc_in_if  in_ch ();
  thpc_out_if out_ch ();

  tcp_header_parse_checksum uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  thpc_segment_checker segment_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_ch.valid),
    .in_ready      (in_ch.ready),
    .in_data       (in_ch.data),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_data      (out_ch.data),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [15:0] segment_csum(input logic [31:0] sa, input logic [31:0] da,
                                               input logic [7:0] pr,
                                               input logic [7:0] body[$]);
    logic [31:0] acc;
    acc = sa[31:16] + sa[15:0] + da[31:16] + da[15:0] + pr + body.size();
    for (int i = 0; i < body.size(); i += 2) begin
      acc += {body[i], (i + 1 < body.size()) ? body[i + 1] : 8'h00};
    end
    while (acc[31:16] != 16'd0) begin
      acc = acc[15:0] + acc[31:16];
    end
    return ~acc[15:0];
  endfunction

  task automatic send_byte(input in_item_t item);
    int gap;
    gap = idle_on ? $urandom_range(0, 12) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.data  <= item;
    in_ch.valid <= 1'b1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic send_segment(input int len, input bit mark_first, input bit mark_last,
                              input int restart_at, input bit fix_csum);
    logic [7:0]  body[$];
    logic [31:0] sa;
    logic [31:0] da;
    logic [7:0]  pr;
    logic [15:0] csum;
    in_item_t    item;
    sa = $urandom();
    da = $urandom();
    pr = 8'($urandom_range(0, 255));
    for (int i = 0; i < len; i++) begin
      body.push_back(8'($urandom_range(0, 255)));
    end
    if (fix_csum) begin
      body[16] = 8'h00;
      body[17] = 8'h00;
      csum = segment_csum(sa, da, pr, body);
      body[16] = csum[15:8];
      body[17] = csum[7:0];
    end
    for (int i = 0; i < len; i++) begin
      item.seg_byte   = body[i];
      item.first_byte = (mark_first && i == 0) || i == restart_at;
      item.last_byte  = mark_last && i == len - 1;
      if (item.first_byte) begin
        item.src_addr  = sa;
        item.dst_addr  = da;
        item.proto_num = pr;
      end else begin
        item.src_addr  = $urandom();
        item.dst_addr  = $urandom();
        item.proto_num = 8'($urandom_range(0, 255));
      end
      send_byte(item);
    end
  endtask

  // sink side: stall a random number of cycles before each summary
  initial begin
    int n;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      n = stall_on ? $urandom_range(0, 12) : 0;
      if (n > 0) begin
        out_ch.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
    end
  end

  initial begin
    int len;
    int kind;
    int restart_at;
    bit mark_first;
    bit mark_last;
    bit fix_csum;
    in_ch.valid <= 1'b0;
    in_ch.data  <= '0;
    rst_n       <= 1'b0;
    idle_on     = 1'b1;
    stall_on    = 1'b1;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // bytes with no first mark right after reset
    send_byte('{8'hFF, 1'b0, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF});
    send_byte('{8'h00, 1'b0, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF});
    send_byte('{8'h80, 1'b0, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF});
    // one-byte segments
    send_byte('{8'hFF, 1'b1, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF});
    send_byte('{8'h00, 1'b1, 1'b1, 32'h0000_0000, 32'h0000_0000, 8'h00});
    // full header, all ones
    for (int i = 0; i < 20; i++) begin
      send_byte('{8'hFF, i == 0, i == 19, 32'h0000_0000, 32'hFFFF_FFFF, 8'h06});
    end

    // overlong segment, length saturates
    idle_on = 1'b0;
    send_segment(65540, 1'b1, 1'b1, -1, 1'b0);

    rand_bytes  = 0;
    rand_closed = 0;
    while (rand_bytes < 1200 || rand_closed < 40) begin
      idle_on  = $urandom_range(0, 5) != 0;
      stall_on = $urandom_range(0, 5) != 0;
      case ($urandom_range(0, 9))
        0, 1:    len = $urandom_range(1, 19);
        9:       len = $urandom_range(49, 120);
        default: len = $urandom_range(20, 48);
      endcase
      kind       = $urandom_range(0, 9);
      mark_first = kind != 0;
      mark_last  = kind != 1;
      restart_at = (kind == 2 && len > 1) ? $urandom_range(1, len - 1) : -1;
      fix_csum   = kind > 2 && len >= 18 && $urandom_range(0, 9) < 6;
      send_segment(len, mark_first, mark_last, restart_at, fix_csum);
      rand_bytes += len;
      if (mark_last) begin
        rand_closed++;
      end
    end

    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #24_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
